### hw/rtl/gamepad_navigation_autorepeat_top_macros.svh
// Assertion helpers for the file that checks internal behavior.
`ifndef GAMEPAD_NAVIGATION_AUTOREPEAT_TOP_MACROS_SVH
`define GAMEPAD_NAVIGATION_AUTOREPEAT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GNA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gna: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define GNA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gna: next-cycle check failed");

`endif

### hw/rtl/gna_pkg.sv
package gna_pkg;

   // Number of navigation directions: up, down, left, right.
   localparam int NumDirs = 4;

   // Highest controller count; an index at or beyond it counts as disconnected.
   localparam int MaxPads = 4;

   // Configuration register indexes.
   localparam logic [1:0] CsrDeadZone       = 2'd0;
   localparam logic [1:0] CsrInitialDelay   = 2'd1;
   localparam logic [1:0] CsrRepeatInterval = 2'd2;

   // Configuration reset values.
   localparam logic [14:0] DeadZoneReset       = 15'd16000;
   localparam logic [15:0] InitialDelayReset   = 16'd400;
   localparam logic [15:0] RepeatIntervalReset = 16'd120;

   // Button word bit positions.
   localparam int BtnDpadUp = 0;
   localparam int BtnDpadDown = 1;
   localparam int BtnDpadLeft = 2;
   localparam int BtnDpadRight = 3;
   localparam int BtnBack = 5;
   localparam int BtnA = 12;
   localparam int BtnB = 13;

   // Result action codes.
   localparam logic [2:0] ActUp       = 3'd0;
   localparam logic [2:0] ActActivate = 3'd4;
   localparam logic [2:0] ActBack     = 3'd5;

   // Positions in the pending-result mask, in delivery order.
   localparam int MaskStatus = 0;
   localparam int MaskDir0 = 1;
   localparam int MaskActivate = 5;
   localparam int MaskBack = 6;
   localparam int MaskW = 7;

   // One classified poll: which results to send and the fields they carry.
   typedef struct packed {
      logic [MaskW-1:0]   mask;
      logic [NumDirs-1:0] dir_alt;
      logic               back_alt;
      logic               conn;
      logic [1:0]         index;
   } gna_entry_type;

endpackage

### hw/rtl/gna_if.sv
// Poll sample channel.
interface gna_req_if;
   logic               valid;
   logic               ready;
   logic               window_active;
   logic               pad_connected;
   logic [1:0]         pad_index;
   logic [15:0]        button_bits;
   logic signed [15:0] stick_x;
   logic signed [15:0] stick_y;
   logic [31:0]        now_ticks;

   modport source (
      output valid, window_active, pad_connected, pad_index, button_bits,
             stick_x, stick_y, now_ticks,
      input  ready
   );
   modport sink (
      input  valid, window_active, pad_connected, pad_index, button_bits,
             stick_x, stick_y, now_ticks,
      output ready
   );
endinterface

// Result channel.
interface gna_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_status;
   logic [2:0] action_code;
   logic       alt_source;
   logic       now_connected;
   logic [1:0] current_index;
   logic       last_of_run;

   modport source (
      output valid, is_status, action_code, alt_source, now_connected,
             current_index, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, is_status, action_code, alt_source, now_connected,
             current_index, last_of_run,
      output ready
   );
endinterface

// Configuration write channel.
interface gna_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/gna_front.sv
module gna_front (
   input  logic                   clock,
   input  logic                   reset,
   gna_req_if.sink                req_ch,
   gna_csr_if.sink                csr_ch,
   input  logic                   queue_full,
   output logic                   push,
   output gna_pkg::gna_entry_type push_entry
);
   import gna_pkg::*;

   logic [14:0] dead_zone_ff, dead_zone_in;
   logic [15:0] delay_ff, delay_in;
   logic [15:0] interval_ff, interval_in;

   logic [NumDirs-1:0] dir_active_ff, dir_active_in;
   logic [31:0]        first_ff [NumDirs];
   logic [31:0]        first_in [NumDirs];
   logic [31:0]        last_ff [NumDirs];
   logic [31:0]        last_in [NumDirs];
   logic               act_held_ff, act_held_in;
   logic               back_held_ff, back_held_in;
   logic               conn_ff, conn_in;
   logic [1:0]         idx_ff, idx_in;

   logic               accept;
   logic               conn_now;
   logic               change;
   logic signed [16:0] dz_pos;
   logic signed [16:0] dz_neg;
   logic signed [16:0] sx_ext;
   logic signed [16:0] sy_ext;
   logic [NumDirs-1:0] dpad;
   logic [NumDirs-1:0] pressed;
   logic [NumDirs-1:0] repeat_ok;
   logic [31:0]        since_first [NumDirs];
   logic [31:0]        since_last [NumDirs];

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !queue_full;
   assign accept = req_ch.valid && !queue_full;

   // Configuration register writes; unknown indexes are dropped.
   always_comb begin
      dead_zone_in = dead_zone_ff;
      delay_in = delay_ff;
      interval_in = interval_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CsrDeadZone:       dead_zone_in = csr_ch.data[14:0];
            CsrInitialDelay:   delay_in = csr_ch.data;
            CsrRepeatInterval: interval_in = csr_ch.data;
            default:           ;
         endcase
      end
   end

   // Classify the sample: connection, direction presses and repeat timing.
   always_comb begin
      conn_now = req_ch.pad_connected && ({1'b0, req_ch.pad_index} < 3'(MaxPads));
      change = (conn_now != conn_ff) || (conn_now && (req_ch.pad_index != idx_ff));
      dz_pos = $signed({2'b00, dead_zone_ff});
      dz_neg = -dz_pos;
      sx_ext = {req_ch.stick_x[15], req_ch.stick_x};
      sy_ext = {req_ch.stick_y[15], req_ch.stick_y};
      dpad[0] = req_ch.button_bits[BtnDpadUp];
      dpad[1] = req_ch.button_bits[BtnDpadDown];
      dpad[2] = req_ch.button_bits[BtnDpadLeft];
      dpad[3] = req_ch.button_bits[BtnDpadRight];
      pressed[0] = dpad[0] || (sy_ext > dz_pos);
      pressed[1] = dpad[1] || (sy_ext < dz_neg);
      pressed[2] = dpad[2] || (sx_ext < dz_neg);
      pressed[3] = dpad[3] || (sx_ext > dz_pos);
      for (int d = 0; d < NumDirs; d++) begin
         since_first[d] = req_ch.now_ticks - first_ff[d];
         since_last[d] = req_ch.now_ticks - last_ff[d];
         repeat_ok[d] = (since_first[d] >= {16'b0, delay_ff}) &&
                        (since_last[d] >= {16'b0, interval_ff});
      end
   end

   // Press state update and the set of results this sample causes.
   always_comb begin
      dir_active_in = dir_active_ff;
      first_in = first_ff;
      last_in = last_ff;
      act_held_in = act_held_ff;
      back_held_in = back_held_ff;
      conn_in = conn_ff;
      idx_in = idx_ff;
      push_entry = '0;
      push = 1'b0;
      if (accept) begin
         if (!req_ch.window_active) begin
            dir_active_in = '0;
            act_held_in = 1'b0;
            back_held_in = 1'b0;
         end else begin
            if (change) begin
               conn_in = conn_now;
               idx_in = conn_now ? req_ch.pad_index : 2'd0;
               dir_active_in = '0;
               act_held_in = 1'b0;
               back_held_in = 1'b0;
               push_entry.mask[MaskStatus] = 1'b1;
            end
            if (conn_now) begin
               for (int d = 0; d < NumDirs; d++) begin
                  push_entry.dir_alt[d] = !dpad[d];
                  if (!pressed[d]) begin
                     dir_active_in[d] = 1'b0;
                  end else if (!dir_active_in[d]) begin
                     dir_active_in[d] = 1'b1;
                     first_in[d] = req_ch.now_ticks;
                     last_in[d] = req_ch.now_ticks;
                     push_entry.mask[MaskDir0 + d] = 1'b1;
                  end else if (repeat_ok[d]) begin
                     last_in[d] = req_ch.now_ticks;
                     push_entry.mask[MaskDir0 + d] = 1'b1;
                  end
               end
               // Activate fires on the rising edge of A only.
               if (!req_ch.button_bits[BtnA]) begin
                  act_held_in = 1'b0;
               end else if (!act_held_in) begin
                  act_held_in = 1'b1;
                  push_entry.mask[MaskActivate] = 1'b1;
               end
               // Back fires on the rising edge of either B or the back button.
               if (!req_ch.button_bits[BtnB] && !req_ch.button_bits[BtnBack]) begin
                  back_held_in = 1'b0;
               end else if (!back_held_in) begin
                  back_held_in = 1'b1;
                  push_entry.mask[MaskBack] = 1'b1;
               end
               push_entry.back_alt = req_ch.button_bits[BtnBack];
            end
            push_entry.conn = conn_in;
            push_entry.index = idx_in;
            push = (push_entry.mask != '0);
         end
      end
   end

   // Control and configuration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DeadZoneReset;
         delay_ff <= InitialDelayReset;
         interval_ff <= RepeatIntervalReset;
         dir_active_ff <= '0;
         act_held_ff <= 1'b0;
         back_held_ff <= 1'b0;
         conn_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         dead_zone_ff <= dead_zone_in;
         delay_ff <= delay_in;
         interval_ff <= interval_in;
         dir_active_ff <= dir_active_in;
         act_held_ff <= act_held_in;
         back_held_ff <= back_held_in;
         conn_ff <= conn_in;
         idx_ff <= idx_in;
      end
   end

   // Press timestamps are only read while their direction is active.
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      last_ff <= last_in;
   end

endmodule

### hw/rtl/gna_queue.sv
module gna_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gna_pkg::gna_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output gna_pkg::gna_entry_type head_entry
);
   import gna_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   gna_entry_type     slots_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full = (count_ff == CntW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/gna_back.sv
module gna_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  gna_pkg::gna_entry_type head_entry,
   output logic                   pop,
   gna_rsp_if.source              rsp_ch
);
   import gna_pkg::*;

   logic [MaskW-1:0] sent_ff, sent_in;
   logic [MaskW-1:0] remaining;
   logic [MaskW-1:0] pick;
   logic             last;
   logic             load;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             is_status_ff, is_status_in;
   logic [2:0]       code_ff, code_in;
   logic             alt_ff, alt_in;
   logic             conn_ff;
   logic [1:0]       index_ff;
   logic             last_ff;

   // Choose the earliest result of the head item not yet sent.
   always_comb begin
      remaining = head_entry.mask & ~sent_ff;
      pick = remaining & (~remaining + 1'b1);
      last = ((remaining & ~pick) == '0);
      load = head_valid && (!rsp_valid_ff || rsp_ch.ready);
      pop = load && last;
      sent_in = sent_ff;
      if (load) begin
         sent_in = last ? '0 : (sent_ff | pick);
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);
   end

   // Decode the chosen mask position into result fields.
   always_comb begin
      is_status_in = pick[MaskStatus];
      code_in = ActUp;
      alt_in = 1'b0;
      for (int d = 0; d < NumDirs; d++) begin
         if (pick[MaskDir0 + d]) begin
            code_in = ActUp + 3'(d);
            alt_in = head_entry.dir_alt[d];
         end
      end
      if (pick[MaskActivate]) begin
         code_in = ActActivate;
      end
      if (pick[MaskBack]) begin
         code_in = ActBack;
         alt_in = head_entry.back_alt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register holds the result until it is taken.
   always_ff @(posedge clock) begin
      if (load) begin
         is_status_ff <= is_status_in;
         code_ff <= code_in;
         alt_ff <= alt_in;
         conn_ff <= head_entry.conn;
         index_ff <= head_entry.index;
         last_ff <= last;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.is_status = is_status_ff;
   assign rsp_ch.action_code = code_ff;
   assign rsp_ch.alt_source = alt_ff;
   assign rsp_ch.now_connected = conn_ff;
   assign rsp_ch.current_index = index_ff;
   assign rsp_ch.last_of_run = last_ff;

endmodule

### hw/rtl/gamepad_navigation_autorepeat_top.sv
// Path: a poll's results pass through the queue slot and then the output register
// before they reach the result channel.
// Throughput: a poll is taken every cycle while the queue has room; results leave
// one per cycle through the single output register while the receiver is ready, so a
// poll with k results (1 to 7) sends them one by one; polls with no result are not queued.
// Reset (synchronous): registers return to 16000/400/120, press and connection
// state clear, the queue and the output register empty.
`include "gamepad_navigation_autorepeat_top_macros.svh"

module gamepad_navigation_autorepeat_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   gna_req_if.sink   req_ch,
   gna_rsp_if.source rsp_ch,
   gna_csr_if.sink   csr_ch
);
   import gna_pkg::*;

   logic          push;
   gna_entry_type push_entry;
   logic          full;
   logic          pop;
   logic          head_valid;
   gna_entry_type head_entry;

   // Front: accepts polls, updates press state, classifies results.
   gna_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue between classification and delivery.
   gna_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back: sends the results of each queued poll one at a time.
   gna_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

   `GNA_ASSERT_IMP(a_push_room, clock, reset, push, !full)
   `GNA_ASSERT_IMP(a_push_nonempty, clock, reset, push, push_entry.mask != '0)
   `GNA_ASSERT_IMP(a_pop_has_head, clock, reset, pop, head_valid)
   `GNA_ASSERT_NEXT(a_pop_sends, clock, reset, pop, rsp_ch.valid && rsp_ch.last_of_run)

endmodule
